// ===== sv/wes_pkg.sv =====
// Shared constants, types and register codes for the 3D wave-equation stencil block.
// Depends on nothing; every other file of the block but wes_delay_ram imports it.
package wes_pkg;

  // Grid geometry.
  localparam int GRID_X      = 64;
  localparam int GRID_Y      = 32;
  localparam int GRID_Z      = 64;
  localparam int PLANE_SIZE  = GRID_X * GRID_Y;
  localparam int POINT_COUNT = PLANE_SIZE * GRID_Z;
  localparam int LAG         = PLANE_SIZE + 1;

  localparam int XW  = $clog2(GRID_X);
  localparam int YW  = $clog2(GRID_Y);
  localparam int ZW  = $clog2(GRID_Z);
  localparam int IPW = $clog2(POINT_COUNT + 1);

  // Depths of the circular delay RAMs between the tap groups of the current-level window.
  localparam int D_ROW   = GRID_X - 3;
  localparam int D_NY    = PLANE_SIZE - 2 * GRID_X - 2;
  localparam int D_MID   = GRID_X - 2;
  localparam int D_PLANE = PLANE_SIZE - GRID_X - 3;

  // Number of three-word tap groups in the window.
  localparam int NUM_GRP = 6;

  // Field and register widths.
  localparam int VAL_W      = 32;
  localparam int COEF_W     = 24;
  localparam int ROW_W      = 5;
  localparam int SLIT_W     = 6;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CMP_W      = 8;
  localparam int FRAC_W     = 24;

  // Datapath widths.
  localparam int LAP_W  = VAL_W + 2;
  localparam int PROD_W = COEF_W + 1 + LAP_W;
  localparam int ACC_W  = PROD_W + 2;
  localparam int RND_W  = ACC_W - FRAC_W;

  localparam logic signed [VAL_W-1:0] VAL_MAX  = {1'b0, {(VAL_W - 1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN  = {1'b1, {(VAL_W - 1){1'b0}}};
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(64'sd1 <<< (FRAC_W - 1));

  // Reset values of the configuration registers.
  localparam logic [COEF_W-1:0] COEF_X_RST     = COEF_W'(397094);
  localparam logic [COEF_W-1:0] COEF_Y_RST     = COEF_W'(620459);
  localparam logic [COEF_W-1:0] COEF_Z_RST     = COEF_W'(397094);
  localparam logic [ROW_W-1:0]  ROW_LOW_RST    = ROW_W'(7);
  localparam logic [ROW_W-1:0]  ROW_HIGH_RST   = ROW_W'(8);
  localparam logic [SLIT_W-1:0] SLIT_LOW_RST   = SLIT_W'(27);
  localparam logic [SLIT_W-1:0] SLIT_HIGH_RST  = SLIT_W'(33);

  typedef logic signed [VAL_W-1:0] val_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEF_X,
    CFG_COEF_Y,
    CFG_COEF_Z,
    CFG_SCREEN_ROW_LOW,
    CFG_SCREEN_ROW_HIGH,
    CFG_SLIT_LOW,
    CFG_SLIT_HIGH
  } cfg_idx_t;

  // Direction in which a boundary coordinate is pulled into the interior.
  typedef enum logic [1:0] {
    CLAMP_UP,
    CLAMP_NONE,
    CLAMP_DOWN
  } clamp_t;

  typedef struct packed {
    logic [COEF_W-1:0] coef_x;
    logic [COEF_W-1:0] coef_y;
    logic [COEF_W-1:0] coef_z;
    logic [ROW_W-1:0]  screen_row_low;
    logic [ROW_W-1:0]  screen_row_high;
    logic [SLIT_W-1:0] slit_low;
    logic [SLIT_W-1:0] slit_high;
  } cfg_t;

  typedef struct packed {
    logic [XW-1:0] x;
    logic [YW-1:0] y;
    logic [ZW-1:0] z;
  } pos_t;

endpackage

// ===== sv/wes_if.sv =====
// Valid/ready channel interfaces of the wave-equation stencil block: input, result, config.
// Depends on wes_pkg for the payload widths.
interface wes_in_if import wes_pkg::*; ();
  logic valid;
  logic ready;
  logic mode;
  val_t cur_value;
  val_t prev_value;
  val_t source_value;

  modport source (output valid, mode, cur_value, prev_value, source_value, input ready);
  modport sink (input valid, mode, cur_value, prev_value, source_value, output ready);
endinterface

interface wes_out_if import wes_pkg::*; ();
  logic valid;
  logic ready;
  val_t new_value;
  logic sweep_done;

  modport source (output valid, new_value, sweep_done, input ready);
  modport sink (input valid, new_value, sweep_done, output ready);
endinterface

interface wes_cfg_if import wes_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/wes_delay_ram.sv =====
// Generic circular-buffer RAM used as a delay line: one write and one registered read in each enabled cycle.
// Self-contained; no package needed.
module wes_delay_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    ptr_r;
  logic [AW-1:0]    ptr_nxt;
  logic [WIDTH-1:0] rd_data_r;

  assign ptr_nxt = (ptr_r == AW'(DEPTH - 1)) ? '0 : ptr_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
    end else if (en) begin
      ptr_r <= ptr_nxt;
    end
  end

  // Read before write at the same slot: the word written at one enable shows up on the
  // output after the DEPTH-th enable that follows.
  always_ff @(posedge clk) begin
    if (en) begin
      rd_data_r    <= mem[ptr_r];
      mem[ptr_r]   <= din;
    end
  end

  assign dout = rd_data_r;

endmodule

// ===== sv/wes_point.sv =====
// Point update of the wave-equation stencil: source plane, clamped boundary copy,
// screen, and the saturated seven-point leapfrog update. Depends on wes_pkg.
module wes_point import wes_pkg::*; (
  input  cfg_t  cfg,
  input  pos_t  pos,
  input  val_t  win [NUM_GRP][3],
  input  val_t  ny_tap,
  input  val_t  prev_value,
  input  val_t  src_value,
  output val_t  new_value,
  output logic  sweep_done
);

  logic   x_lo, x_hi, y_lo, y_hi, z_lo, z_hi, on_edge;
  clamp_t dx_sel, dz_sel;
  val_t   row [3];
  val_t   clamp_val;
  logic   in_band, x_in_slit, z_in_slit, screened;
  val_t   c, xp, xm, yp, ym, zp, zm;
  logic signed [LAP_W-1:0]  lap_x, lap_y, lap_z, two_c_p;
  logic signed [PROD_W-1:0] prod_x, prod_y, prod_z;
  logic signed [ACC_W-1:0]  acc;
  logic signed [RND_W-1:0]  rnd;
  val_t   sat_val;

  assign x_lo = (pos.x == '0);
  assign x_hi = (pos.x == XW'(GRID_X - 1));
  assign y_lo = (pos.y == '0);
  assign y_hi = (pos.y == YW'(GRID_Y - 1));
  assign z_lo = (pos.z == '0);
  assign z_hi = (pos.z == ZW'(GRID_Z - 1));
  assign on_edge = x_lo | x_hi | y_hi | z_lo | z_hi;
  assign sweep_done = x_hi & y_hi & z_hi;

  assign dx_sel = x_lo ? CLAMP_UP : (x_hi ? CLAMP_DOWN : CLAMP_NONE);
  assign dz_sel = z_lo ? CLAMP_UP : (z_hi ? CLAMP_DOWN : CLAMP_NONE);

  // Groups are ordered by age: the z offset picks a pair, the top y row picks within it.
  always_comb begin
    row = win[2];
    unique case (dz_sel)
      CLAMP_UP: begin
        if (y_hi) row = win[1];
        else      row = win[0];
      end
      CLAMP_NONE: begin
        if (y_hi) row = win[3];
        else      row = win[2];
      end
      CLAMP_DOWN: begin
        if (y_hi) row = win[5];
        else      row = win[4];
      end
      default: row = win[2];
    endcase
  end

  always_comb begin
    unique case (dx_sel)
      CLAMP_UP:   clamp_val = row[0];
      CLAMP_NONE: clamp_val = row[1];
      CLAMP_DOWN: clamp_val = row[2];
      default:    clamp_val = row[1];
    endcase
  end

  assign in_band   = (CMP_W'(pos.y) >= CMP_W'(cfg.screen_row_low)) &&
                     (CMP_W'(pos.y) <= CMP_W'(cfg.screen_row_high));
  assign x_in_slit = (CMP_W'(pos.x) >= CMP_W'(cfg.slit_low)) &&
                     (CMP_W'(pos.x) <= CMP_W'(cfg.slit_high));
  assign z_in_slit = (CMP_W'(pos.z) >= CMP_W'(cfg.slit_low)) &&
                     (CMP_W'(pos.z) <= CMP_W'(cfg.slit_high));
  assign screened  = in_band && !x_in_slit && !z_in_slit;

  assign c  = win[2][1];
  assign xp = win[2][0];
  assign xm = win[2][2];
  assign yp = ny_tap;
  assign ym = win[3][1];
  assign zp = win[0][1];
  assign zm = win[4][1];

  assign lap_x   = LAP_W'(xp) + LAP_W'(xm) - (LAP_W'(c) <<< 1);
  assign lap_y   = LAP_W'(yp) + LAP_W'(ym) - (LAP_W'(c) <<< 1);
  assign lap_z   = LAP_W'(zp) + LAP_W'(zm) - (LAP_W'(c) <<< 1);
  assign two_c_p = (LAP_W'(c) <<< 1) - LAP_W'(prev_value);

  assign prod_x = $signed({1'b0, cfg.coef_x}) * lap_x;
  assign prod_y = $signed({1'b0, cfg.coef_y}) * lap_y;
  assign prod_z = $signed({1'b0, cfg.coef_z}) * lap_z;

  // Sum at 24 fraction bits, then round half up to an integer by a floor shift.
  assign acc = ACC_W'(prod_x) + ACC_W'(prod_y) + ACC_W'(prod_z) +
               (ACC_W'(two_c_p) <<< FRAC_W) + RND_HALF;
  assign rnd = RND_W'(acc >>> FRAC_W);

  always_comb begin
    if (rnd > RND_W'(VAL_MAX))      sat_val = VAL_MAX;
    else if (rnd < RND_W'(VAL_MIN)) sat_val = VAL_MIN;
    else                            sat_val = VAL_W'(rnd);
  end

  always_comb begin
    priority if (y_lo)    new_value = src_value;
    else if (on_edge)     new_value = clamp_val;
    else if (screened)    new_value = '0;
    else                  new_value = sat_val;
  end

endmodule

// ===== sv/wave_equation_stencil_3d_unit.sv =====
// Top level of the streaming 3D wave-equation stencil: window delay lines, position
// counters, configuration registers and result register. Depends on wes_pkg, wes_if,
// wes_delay_ram and wes_point.

// The block computes one leapfrog time step of the 3D scalar wave equation on a
// GRID_X x GRID_Y x GRID_Z grid streamed in raster order (x fastest, then y, then z).
// Each input word carries the current level, the previous level and the source drive
// for the y=0 plane; each result word is the next level of the point one plane plus one
// point behind the newest input, so the first result follows the (GRID_X*GRID_Y+2)-th
// grid word and the last GRID_X*GRID_Y+1 results are drained by sending further words
// (flush words, or any word once the whole grid is in; their data are ignored). A flush
// word sent before the grid is complete is taken and dropped. The block takes one word
// per clock and gives at most one result per clock; a result is registered from the
// window stage that the completing word fills. The input keeps flowing while one result
// waits to be taken, and stalls only once a second point is held in the window stage
// behind it. The cycle time is set by the point datapath, where three 25 x 34 bit
// products are summed, rounded and saturated between the window taps and the result
// register. The current level is held in a window of two planes plus a few points, built
// from six circular delay RAMs with short register runs at the taps; the previous level
// goes through one delay RAM of one plane plus one point. Every window read comes from
// words of the running sweep, so no clearing pass is needed after reset. Configuration
// writes are taken at any time but belong between sweeps while no result is pending.
module wave_equation_stencil_3d_unit import wes_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  wes_in_if.sink     in_ch,
  wes_out_if.source  out_ch,
  wes_cfg_if.sink    cfg_ch
);

  // Handshake and sequencing.
  logic draining, grid_acc, drain_acc, shift, emit;
  logic in_ready, in_fire, can_move, move, o_last;

  logic [IPW-1:0] in_pos_r, in_pos_nxt;
  pos_t           o_pos_r, o_pos_nxt;
  pos_t           s1_pos_r;
  logic           s1_pend_r;
  val_t           src_hold_r;
  cfg_t           cfg_r;

  // Current-level window: group heads come from the delay RAMs, except the newest word.
  val_t head0_r;
  val_t tail_r [NUM_GRP][2];
  val_t grp_head [NUM_GRP];
  val_t win [NUM_GRP][3];
  val_t ny_tap;
  val_t prev_tap;

  val_t pt_value;
  logic pt_done;

  logic out_valid_r;
  val_t out_new_value_r;
  logic out_sweep_done_r;

  // A word moves the window when it is a grid word or when the grid is fully in.
  assign draining  = (in_pos_r == IPW'(POINT_COUNT));
  assign can_move  = !out_valid_r || out_ch.ready;
  assign in_ready  = !s1_pend_r || can_move;
  assign in_fire   = in_ch.valid && in_ready;
  assign grid_acc  = in_fire && !draining && !in_ch.mode;
  assign drain_acc = in_fire && draining;
  assign shift     = grid_acc || drain_acc;
  assign emit      = drain_acc || (grid_acc && (in_pos_r >= IPW'(LAG)));
  assign move      = s1_pend_r && can_move;

  assign in_ch.ready = in_ready;

  assign o_last = (o_pos_r.x == XW'(GRID_X - 1)) && (o_pos_r.y == YW'(GRID_Y - 1)) &&
                  (o_pos_r.z == ZW'(GRID_Z - 1));

  // Output raster position, advanced once per emitted point.
  always_comb begin
    o_pos_nxt = o_pos_r;
    if (emit) begin
      if (o_pos_r.x != XW'(GRID_X - 1)) begin
        o_pos_nxt.x = o_pos_r.x + 1'b1;
      end else begin
        o_pos_nxt.x = '0;
        if (o_pos_r.y != YW'(GRID_Y - 1)) begin
          o_pos_nxt.y = o_pos_r.y + 1'b1;
        end else begin
          o_pos_nxt.y = '0;
          if (o_pos_r.z != ZW'(GRID_Z - 1)) o_pos_nxt.z = o_pos_r.z + 1'b1;
          else                              o_pos_nxt.z = '0;
        end
      end
    end
  end

  // The sweep ends with its last point; both positions start over.
  always_comb begin
    in_pos_nxt = in_pos_r;
    priority if (emit && o_last) in_pos_nxt = '0;
    else if (grid_acc)           in_pos_nxt = in_pos_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_pos_r  <= '0;
      o_pos_r   <= '0;
      s1_pend_r <= 1'b0;
    end else begin
      in_pos_r <= in_pos_nxt;
      o_pos_r  <= o_pos_nxt;
      if (emit)      s1_pend_r <= 1'b1;
      else if (move) s1_pend_r <= 1'b0;
    end
  end

  // The point waiting in the window stage keeps its position until it moves out.
  always_ff @(posedge clk) begin
    if (emit) s1_pos_r <= o_pos_r;
  end

  // The drive value follows every grid word; drained points reuse the last one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_hold_r <= '0;
    end else if (grid_acc) begin
      src_hold_r <= in_ch.source_value;
    end
  end

  // Window shift: each group is a head followed by two registers.
  always_ff @(posedge clk) begin
    if (shift) begin
      head0_r <= in_ch.cur_value;
      for (int j = 0; j < NUM_GRP; j++) begin
        tail_r[j][0] <= grp_head[j];
        tail_r[j][1] <= tail_r[j][0];
      end
    end
  end

  assign grp_head[0] = head0_r;

  always_comb begin
    for (int j = 0; j < NUM_GRP; j++) begin
      win[j][0] = grp_head[j];
      win[j][1] = tail_r[j][0];
      win[j][2] = tail_r[j][1];
    end
  end

  // Delay RAMs between the tap groups; each adds its depth plus one word of delay.
  wes_delay_ram #(.WIDTH(VAL_W), .DEPTH(D_ROW)) u_row_a (
    .clk(clk), .rst_n(rst_n), .en(shift), .din(tail_r[0][1]), .dout(grp_head[1])
  );

  wes_delay_ram #(.WIDTH(VAL_W), .DEPTH(D_NY)) u_ny (
    .clk(clk), .rst_n(rst_n), .en(shift), .din(tail_r[1][1]), .dout(ny_tap)
  );

  wes_delay_ram #(.WIDTH(VAL_W), .DEPTH(D_MID)) u_mid (
    .clk(clk), .rst_n(rst_n), .en(shift), .din(ny_tap), .dout(grp_head[2])
  );

  wes_delay_ram #(.WIDTH(VAL_W), .DEPTH(D_ROW)) u_row_b (
    .clk(clk), .rst_n(rst_n), .en(shift), .din(tail_r[2][1]), .dout(grp_head[3])
  );

  wes_delay_ram #(.WIDTH(VAL_W), .DEPTH(D_PLANE)) u_plane (
    .clk(clk), .rst_n(rst_n), .en(shift), .din(tail_r[3][1]), .dout(grp_head[4])
  );

  wes_delay_ram #(.WIDTH(VAL_W), .DEPTH(D_ROW)) u_row_c (
    .clk(clk), .rst_n(rst_n), .en(shift), .din(tail_r[4][1]), .dout(grp_head[5])
  );

  // Previous level, delayed by exactly one plane plus one point of window shifts.
  wes_delay_ram #(.WIDTH(VAL_W), .DEPTH(LAG)) u_prev (
    .clk(clk), .rst_n(rst_n), .en(shift), .din(in_ch.prev_value), .dout(prev_tap)
  );

  wes_point u_point (
    .cfg        (cfg_r),
    .pos        (s1_pos_r),
    .win        (win),
    .ny_tap     (ny_tap),
    .prev_value (prev_tap),
    .src_value  (src_hold_r),
    .new_value  (pt_value),
    .sweep_done (pt_done)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (move) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_new_value_r  <= pt_value;
      out_sweep_done_r <= pt_done;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.new_value  = out_new_value_r;
  assign out_ch.sweep_done = out_sweep_done_r;

  // Configuration registers; writes to an unused index are dropped.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.coef_x          <= COEF_X_RST;
      cfg_r.coef_y          <= COEF_Y_RST;
      cfg_r.coef_z          <= COEF_Z_RST;
      cfg_r.screen_row_low  <= ROW_LOW_RST;
      cfg_r.screen_row_high <= ROW_HIGH_RST;
      cfg_r.slit_low        <= SLIT_LOW_RST;
      cfg_r.slit_high       <= SLIT_HIGH_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        CFG_COEF_X:          cfg_r.coef_x          <= cfg_ch.data[COEF_W-1:0];
        CFG_COEF_Y:          cfg_r.coef_y          <= cfg_ch.data[COEF_W-1:0];
        CFG_COEF_Z:          cfg_r.coef_z          <= cfg_ch.data[COEF_W-1:0];
        CFG_SCREEN_ROW_LOW:  cfg_r.screen_row_low  <= cfg_ch.data[ROW_W-1:0];
        CFG_SCREEN_ROW_HIGH: cfg_r.screen_row_high <= cfg_ch.data[ROW_W-1:0];
        CFG_SLIT_LOW:        cfg_r.slit_low        <= cfg_ch.data[SLIT_W-1:0];
        CFG_SLIT_HIGH:       cfg_r.slit_high       <= cfg_ch.data[SLIT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule
